/* hdl/b10knd_pkg.sv */
// ----------------------------------------------------------------------------
// b10knd_pkg
// Shared types, codes and helpers of the base-10000 numeric decoder.
// ----------------------------------------------------------------------------
package b10knd_pkg;

  // Default depth of the command queue between front and back end
  localparam int QUEUE_DEPTH_DEF = 4;

  // Sign codes of header word 2
  localparam logic [15:0] SIGN_POS  = 16'h0000;
  localparam logic [15:0] SIGN_NEG  = 16'h4000;
  localparam logic [15:0] SIGN_NAN  = 16'hC000;
  localparam logic [15:0] SIGN_PINF = 16'hD000;
  localparam logic [15:0] SIGN_NINF = 16'hF000;

  // Largest legal base-10000 digit word
  localparam logic [15:0] MAX_DIGIT_WORD = 16'd9999;

  // Header length in words
  localparam logic [16:0] HDR_WORDS = 17'd4;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_DIGIT   = 3'd1,
    KIND_NAN     = 3'd2,
    KIND_PINF    = 3'd3,
    KIND_NINF    = 3'd4,
    KIND_END_OK  = 3'd5,
    KIND_END_ERR = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_SIGN   = 2'd2,
    ERR_DIGIT  = 2'd3
  } err_t;

  // Input word
  typedef struct packed {
    logic [15:0] word;
    logic        final_word;
  } in_t;

  // Result word
  typedef struct packed {
    kind_t              kind;
    logic               negative;
    logic signed [19:0] exponent;
    logic [3:0]         digit;
    err_t               error_code;
    logic               last;
  } out_t;

  // Command from front end to back end: optional lead result,
  // up to four digits of one digit word, optional closing result
  typedef struct packed {
    logic               lead;
    kind_t              lead_kind;
    logic               negative;
    logic signed [19:0] exponent;
    logic [2:0]         dig_cnt;
    logic [13:0]        dig_word;
    logic               end_pend;
    err_t               end_err;
  } cmd_t;

  // k times the decimal place weight of digit position pos (0 = thousands)
  function automatic logic [13:0] place_mult(input logic [1:0] pos, input logic [3:0] k);
    logic [13:0] p;
    begin
      case (pos)
        2'd0:    p = 14'd1000;
        2'd1:    p = 14'd100;
        2'd2:    p = 14'd10;
        default: p = 14'd1;
      endcase
      place_mult = 14'(p * {10'd0, k});
    end
  endfunction

endpackage

/* hdl/base10000_numeric_decoder.sv */
// ----------------------------------------------------------------------------
// base10000_numeric_decoder
// Decodes a binary base-10000 numeric value, one 16-bit word at a time,
// into a header or special word, decimal digits and a closing status word.
// ----------------------------------------------------------------------------
//
//  port group   direction  payload    handshake
//  in_*         input      in_t       in_valid / in_ready
//  out_*        output     out_t      out_valid / out_ready
//
//  The front end takes one word per cycle while the command queue has room.
//  The back end emits one result word per cycle while the output does not
//  stall. A digit word yields up to four digits; the back end's single output
//  slot sets the sustained rate. The queue of QUEUE_DEPTH commands lets the
//  front keep accepting while results drain or the output stalls.
//  Synchronous reset clears the header state, the queue and the output slot.
// ----------------------------------------------------------------------------
module base10000_numeric_decoder #(
  parameter int QUEUE_DEPTH = b10knd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  b10knd_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output b10knd_pkg::out_t  out_data
);
  import b10knd_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_wdata, q_rdata;

  b10knd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  b10knd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  b10knd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/b10knd_front.sv */
// ----------------------------------------------------------------------------
// b10knd_front
// Accepts input words, tracks the header and the digit budget, checks the
// value and pushes one command per word that causes results.
// ----------------------------------------------------------------------------
module b10knd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  b10knd_pkg::in_t   in_data,
  input  logic              q_full,
  output logic              q_push,
  output b10knd_pkg::cmd_t  q_data
);
  import b10knd_pkg::*;

  logic [16:0]        idx_r, idx_nxt, idx_inc;
  logic [15:0]        dwc_r, dwc_nxt;
  logic signed [19:0] negexp_r, negexp_nxt;
  logic               special_r, special_nxt;
  logic               neg_r, neg_nxt;
  err_t               sticky_r, sticky_nxt;
  logic [17:0]        dleft_r, dleft_nxt;

  logic               acc;
  logic [15:0]        w;
  logic [17:0]        base_sum;
  logic signed [19:0] scale20, trim, hdr_exp;
  logic               trim_on;
  logic [17:0]        nd, nd_cut;
  logic [2:0]         cnt;
  logic               len_bad;
  cmd_t               cmd;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign w        = in_data.word;
  assign idx_inc  = (idx_r == '1) ? idx_r : idx_r + 17'd1;

  // dwc - weight - 1, via dwc + ~weight
  assign base_sum = {2'b00, dwc_r} + {{2{~w[15]}}, ~w};

  // header: exponent and trimmed digit count
  assign scale20 = $signed({4'd0, w});
  assign trim    = negexp_r - scale20;
  assign trim_on = (w != 16'd0) && (trim > 20'sd0);
  assign nd      = {dwc_r, 2'b00};
  assign hdr_exp = trim_on ? -scale20 : -negexp_r;
  always_comb begin
    if (!trim_on) begin
      nd_cut = nd;
    end else if ({1'b0, nd} > trim[18:0]) begin
      nd_cut = nd - trim[17:0];
    end else begin
      nd_cut = '0;
    end
  end

  assign cnt     = (dleft_r >= 18'd4) ? 3'd4 : dleft_r[2:0];
  assign len_bad = (idx_inc < HDR_WORDS) || (idx_inc != ({1'b0, dwc_r} + HDR_WORDS));

  // word classification
  always_comb begin
    idx_nxt     = idx_r;
    dwc_nxt     = dwc_r;
    negexp_nxt  = negexp_r;
    special_nxt = special_r;
    neg_nxt     = neg_r;
    sticky_nxt  = sticky_r;
    dleft_nxt   = dleft_r;
    cmd         = '0;
    cmd.lead_kind = KIND_HEADER;
    cmd.end_err   = ERR_NONE;
    if (acc) begin
      if (idx_r == 17'd0) begin
        dwc_nxt = w;
      end else if (idx_r == 17'd1) begin
        negexp_nxt = $signed({base_sum, 2'b00});
      end else if (idx_r == 17'd2) begin
        special_nxt = 1'b0;
        neg_nxt     = 1'b0;
        dleft_nxt   = '0;
        case (w)
          SIGN_NAN: begin
            special_nxt   = 1'b1;
            cmd.lead      = 1'b1;
            cmd.lead_kind = KIND_NAN;
          end
          SIGN_PINF: begin
            special_nxt   = 1'b1;
            cmd.lead      = 1'b1;
            cmd.lead_kind = KIND_PINF;
          end
          SIGN_NINF: begin
            special_nxt   = 1'b1;
            cmd.lead      = 1'b1;
            cmd.lead_kind = KIND_NINF;
          end
          SIGN_NEG: begin
            neg_nxt = 1'b1;
          end
          SIGN_POS: begin
            neg_nxt = 1'b0;
          end
          default: begin
            if (sticky_r == ERR_NONE) begin
              sticky_nxt = ERR_SIGN;
            end
          end
        endcase
      end else if (idx_r == 17'd3) begin
        neg_nxt   = 1'b0;
        dleft_nxt = '0;
        if (!special_r && sticky_r == ERR_NONE) begin
          cmd.lead      = 1'b1;
          cmd.lead_kind = KIND_HEADER;
          cmd.negative  = neg_r;
          cmd.exponent  = hdr_exp;
          dleft_nxt     = nd_cut;
        end
      end else if (!special_r && sticky_r == ERR_NONE && dleft_r != 18'd0) begin
        if (w > MAX_DIGIT_WORD) begin
          sticky_nxt = ERR_DIGIT;
        end else begin
          cmd.dig_cnt  = cnt;
          cmd.dig_word = w[13:0];
          dleft_nxt    = dleft_r - {15'd0, cnt};
        end
      end
      idx_nxt = idx_inc;

      // closing word: report and start over
      if (in_data.final_word) begin
        cmd.end_pend = 1'b1;
        cmd.end_err  = len_bad ? ERR_LENGTH : sticky_nxt;
        idx_nxt      = '0;
        dwc_nxt      = '0;
        negexp_nxt   = '0;
        special_nxt  = 1'b0;
        neg_nxt      = 1'b0;
        sticky_nxt   = ERR_NONE;
        dleft_nxt    = '0;
      end
    end
  end

  assign q_push = acc && (cmd.lead || cmd.dig_cnt != 3'd0 || cmd.end_pend);
  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      dwc_r     <= '0;
      negexp_r  <= '0;
      special_r <= 1'b0;
      neg_r     <= 1'b0;
      sticky_r  <= ERR_NONE;
      dleft_r   <= '0;
    end else begin
      idx_r     <= idx_nxt;
      dwc_r     <= dwc_nxt;
      negexp_r  <= negexp_nxt;
      special_r <= special_nxt;
      neg_r     <= neg_nxt;
      sticky_r  <= sticky_nxt;
      dleft_r   <= dleft_nxt;
    end
  end

endmodule

/* hdl/b10knd_queue.sv */
// ----------------------------------------------------------------------------
// b10knd_queue
// Small command FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module b10knd_queue #(
  parameter int DEPTH = b10knd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  b10knd_pkg::cmd_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output b10knd_pkg::cmd_t  pop_data
);
  import b10knd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full     = (cnt_r == FULL_CNT);
  assign valid    = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

/* hdl/b10knd_back.sv */
// ----------------------------------------------------------------------------
// b10knd_back
// Carries out commands: emits lead, digit and closing words into an output
// register, one per cycle unless stalled; digit words split by decimal place.
// ----------------------------------------------------------------------------
module b10knd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  b10knd_pkg::cmd_t  q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output b10knd_pkg::out_t  out_data
);
  import b10knd_pkg::*;

  logic        cur_valid_r;
  cmd_t        cmd_r, cmd_nxt;
  logic [1:0]  pos_r;
  logic [13:0] rem_r, rem_nxt;
  logic        out_valid_r;
  out_t        out_r, res;

  logic        slot_free, emit, cur_last;
  logic [3:0]  dig;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = cur_valid_r && slot_free;

  // next decimal digit of the remainder
  always_comb begin
    dig = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_r >= place_mult(pos_r, 4'(k))) begin
        dig = 4'(k);
      end
    end
  end
  assign rem_nxt = rem_r - place_mult(pos_r, dig);

  // select next word of the current command
  always_comb begin
    res            = '0;
    res.kind       = KIND_END_OK;
    res.error_code = ERR_NONE;
    cmd_nxt        = cmd_r;
    if (cmd_r.lead) begin
      res.kind      = cmd_r.lead_kind;
      res.negative  = cmd_r.negative;
      res.exponent  = cmd_r.exponent;
      cmd_nxt.lead  = 1'b0;
      cur_last      = (cmd_r.dig_cnt == 3'd0) && !cmd_r.end_pend;
    end else if (cmd_r.dig_cnt != 3'd0) begin
      res.kind        = KIND_DIGIT;
      res.digit       = dig;
      cmd_nxt.dig_cnt = cmd_r.dig_cnt - 3'd1;
      cur_last        = (cmd_r.dig_cnt == 3'd1) && !cmd_r.end_pend;
    end else begin
      res.kind         = (cmd_r.end_err == ERR_NONE) ? KIND_END_OK : KIND_END_ERR;
      res.error_code   = cmd_r.end_err;
      res.last         = 1'b1;
      cmd_nxt.end_pend = 1'b0;
      cur_last         = 1'b1;
    end
  end

  assign q_pop = q_valid && (!cur_valid_r || (emit && cur_last));

  // current command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
    end else if (emit && cur_last) begin
      cur_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
      rem_r <= q_data.dig_word;
      pos_r <= 2'd0;
    end else if (emit) begin
      cmd_r <= cmd_nxt;
      if (!cmd_r.lead && cmd_r.dig_cnt != 3'd0) begin
        rem_r <= rem_nxt;
        pos_r <= pos_r + 2'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/b10knd_checker.sv */
// ----------------------------------------------------------------------------
// b10knd_props
// Port-level checks of the numeric decoder's result stream.
// ----------------------------------------------------------------------------
module b10knd_props (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input b10knd_pkg::out_t  out_data
);
  import b10knd_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // last flag marks exactly the closing words
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last ==
      (out_data.kind == KIND_END_OK || out_data.kind == KIND_END_ERR)))
    else $error("last flag does not match kind");

  // closing status agrees with error code
  a_end_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |->
      ((out_data.kind == KIND_END_OK) == (out_data.error_code == ERR_NONE)))
    else $error("closing kind and error code disagree");

  // digits stay decimal
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_DIGIT |-> out_data.digit <= 4'd9)
    else $error("digit above nine");

endmodule

bind base10000_numeric_decoder b10knd_props u_b10knd_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
